// File: src/mm4_pkg.sv
// shared constants, types and helpers for the 4x4 q16.16 matrix multiplier
// no dependencies; imported by every module of the block

package mm4_pkg;

   localparam int DIM = 4;
   localparam int FRAC_BITS = 16;
   localparam int IDX_W = $clog2(DIM);
   localparam int ADDR_W = 2 * IDX_W;
   localparam int DEPTH = DIM * DIM;
   localparam int DATA_W = 32;
   localparam int PROD_W = 2 * DATA_W;
   localparam int ACC_W = PROD_W + $clog2(DIM);
   localparam int ACT_W = 2;
   localparam int FIELDS_W = 2 * IDX_W + DATA_W;
   localparam int TDATA_W = ((FIELDS_W + 7) / 8) * 8;
   localparam int PAD_W = TDATA_W - FIELDS_W;

   localparam logic [ACT_W-1:0] ACT_LOAD_LEFT = 2'd0;
   localparam logic [ACT_W-1:0] ACT_LOAD_RIGHT = 2'd1;
   localparam logic [ACT_W-1:0] ACT_MULTIPLY = 2'd2;

   localparam logic [IDX_W-1:0] K_LAST = IDX_W'(DIM - 1);
   localparam logic [ADDR_W-1:0] ELEM_LAST = ADDR_W'(DEPTH - 1);

   localparam logic signed [ACC_W-1:0] SAT_HI =
      {{(ACC_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SAT_LO =
      {{(ACC_W - DATA_W + 1){1'b1}}, {(DATA_W - 1){1'b0}}};

   // control that travels with a dot-product term
   typedef struct packed {
      logic vld;    // term present
      logic first;  // first term of an element
      logic fin;    // final term of an element
   } mac_ctl_type;

   // floor shift by the fraction width, then clamp to signed 32 bits
   function automatic logic [DATA_W-1:0] sat_q16(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] sh;
      sh = acc >>> FRAC_BITS;
      if (sh > SAT_HI) begin
         sat_q16 = SAT_HI[DATA_W-1:0];
      end else if (sh < SAT_LO) begin
         sat_q16 = SAT_LO[DATA_W-1:0];
      end else begin
         sat_q16 = sh[DATA_W-1:0];
      end
   endfunction

endpackage

// File: src/mm4_store.sv
// one matrix store: dim*dim words, one write and one registered read per cycle
// uses mm4_pkg; per-entry valid bits make unwritten entries read as zero

module mm4_store
   import mm4_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]  vld_ff;
   logic [DATA_W-1:0] rd_data_ff;
   logic              rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         rd_vld_ff <= vld_ff[rd_addr];
      end
   end

   // never-written entries read as zero, since their valid bit is still clear
   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

// File: src/mm4_mac.sv
// multiply-accumulate pipeline: registered 32x32 product, then running sum
// uses mm4_pkg; done pulses with the full-precision sum of one element

module mm4_mac
   import mm4_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  mac_ctl_type             ctl,
   input  logic [DATA_W-1:0]       op_a,
   input  logic [DATA_W-1:0]       op_b,
   output logic                    done,
   output logic signed [ACC_W-1:0] acc
);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  prod_ext;
   mac_ctl_type              ctl_ff;
   logic                     done_ff;

   assign prod_ext = ACC_W'(prod_ff);

   always_comb begin
      if (ctl_ff.first) begin
         acc_in = prod_ext;
      end else begin
         acc_in = acc_ff + prod_ext;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= $signed(op_a) * $signed(op_b);
      if (ctl_ff.vld) begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         ctl_ff  <= ctl;
         done_ff <= ctl_ff.vld && ctl_ff.fin;
      end
   end

   assign done = done_ff;
   assign acc  = acc_ff;

endmodule

// File: src/matrix_multiply_4x4.sv
// top level of the 4x4 q16.16 matrix multiplier: stream ports and sequencer
// depends on mm4_pkg, mm4_store (two instances) and mm4_mac

// A load item (tuser 0 or 1) writes one element of the left or the right
// matrix; both matrices read as zero after reset. A multiply item (tuser 2)
// produces sixteen result items, column by column with the row running inner,
// the last one marked by tlast; tuser 3 is accepted and ignored. Each product
// element is the sum of four 32x32 products, floor-shifted right by 16 and
// saturated to signed 32 bits. Each matrix lives in its own single-read-port
// memory, so one dot term is read per cycle once an element has started; a
// result passes through four reads, the registered memory read, the product
// register and the accumulate, and the next element starts only after it is
// done. A multiply occupies the block until its last element is done, longer
// when the result side stalls. The input side is not ready while a multiply
// runs, so loads never overlap reads of the stores. No clearing pass after reset.

module matrix_multiply_4x4
   import mm4_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [TDATA_W-1:0] req_tdata,  // row, col, value, zero pad
   input  logic [ACT_W-1:0]   req_tuser,  // action
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [TDATA_W-1:0] rsp_tdata,  // out_row, out_col, product, zero pad
   output logic               rsp_tlast
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN = 1'b1;

   // input fields
   logic [IDX_W-1:0]  req_row;
   logic [IDX_W-1:0]  req_col;
   logic [DATA_W-1:0] req_value;
   logic              req_accept;

   assign req_row   = req_tdata[IDX_W-1:0];
   assign req_col   = req_tdata[2*IDX_W-1:IDX_W];
   assign req_value = req_tdata[FIELDS_W-1:2*IDX_W];

   // sequencer state
   logic              state_ff, state_in;
   logic [ADDR_W-1:0] elem_ff, elem_in;     // {col, row} of the element in work
   logic [IDX_W-1:0]  k_ff, k_in;          // dot-product term being read
   logic              inflight_ff, inflight_in;
   logic [IDX_W-1:0]  elem_row;
   logic [IDX_W-1:0]  elem_col;
   logic              rsp_free;
   logic              issue;
   mac_ctl_type       ctl_s1_ff;

   // result register
   logic              rsp_valid_ff;
   logic [IDX_W-1:0]  rsp_row_ff;
   logic [IDX_W-1:0]  rsp_col_ff;
   logic [DATA_W-1:0] rsp_product_ff;
   logic              rsp_last_ff;

   // datapath
   logic [DATA_W-1:0]       left_rd;
   logic [DATA_W-1:0]       right_rd;
   logic                    mac_done;
   logic signed [ACC_W-1:0] mac_acc;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   assign elem_row = elem_ff[IDX_W-1:0];
   assign elem_col = elem_ff[ADDR_W-1:IDX_W];

   // start an element only when the result register will have room for it
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign issue    = (state_ff == ST_RUN) && ((k_ff != '0) || (!inflight_ff && rsp_free));

   // left element (row, k) and right element (k, col)
   mm4_store u_left (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (req_accept && (req_tuser == ACT_LOAD_LEFT)),
      .wr_addr ({req_row, req_col}),
      .wr_data (req_value),
      .rd_addr ({elem_row, k_ff}),
      .rd_data (left_rd)
   );

   mm4_store u_right (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (req_accept && (req_tuser == ACT_LOAD_RIGHT)),
      .wr_addr ({req_row, req_col}),
      .wr_data (req_value),
      .rd_addr ({k_ff, elem_col}),
      .rd_data (right_rd)
   );

   mm4_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl_s1_ff),
      .op_a  (left_rd),
      .op_b  (right_rd),
      .done  (mac_done),
      .acc   (mac_acc)
   );

   always_comb begin
      state_in    = state_ff;
      elem_in     = elem_ff;
      k_in        = k_ff;
      inflight_in = inflight_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_tuser == ACT_MULTIPLY)) begin
               state_in    = ST_RUN;
               elem_in     = '0;
               k_in        = '0;
               inflight_in = 1'b0;
            end
         end
         ST_RUN: begin
            if (issue) begin
               k_in = (k_ff == K_LAST) ? '0 : k_ff + 1'b1;
               if (k_ff == '0) begin
                  inflight_in = 1'b1;
               end
            end
            // element finished: move on, or stop after the final one
            if (mac_done) begin
               inflight_in = 1'b0;
               elem_in     = elem_ff + 1'b1;
               if (elem_ff == ELEM_LAST) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         elem_ff      <= '0;
         k_ff         <= '0;
         inflight_ff  <= 1'b0;
         ctl_s1_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         elem_ff     <= elem_in;
         k_ff        <= k_in;
         inflight_ff <= inflight_in;
         // control lines up with the registered read data of the stores
         ctl_s1_ff.vld   <= issue;
         ctl_s1_ff.first <= (k_ff == '0);
         ctl_s1_ff.fin   <= (k_ff == K_LAST);
         if (mac_done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload, captured once per element
   always_ff @(posedge clock) begin
      if (mac_done) begin
         rsp_row_ff     <= elem_row;
         rsp_col_ff     <= elem_col;
         rsp_product_ff <= sat_q16(mac_acc);
         rsp_last_ff    <= (elem_ff == ELEM_LAST);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_product_ff, rsp_col_ff, rsp_row_ff};
   assign rsp_tlast  = rsp_last_ff;

   // loads must never land while an element is being read
   a_no_load_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !inflight_ff)
      else $error("input ready while an element is in flight");

   // a finished element must always find room in the result register
   a_no_result_overrun: assert property (@(posedge clock) disable iff (reset)
      mac_done |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overrun");

   // the term counter rests at zero whenever the block is idle
   a_idle_k_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (k_ff == '0))
      else $error("term counter not at zero while idle");

   // a marked result ends the run and leaves the block idle
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (mac_done && (elem_ff == ELEM_LAST)) |=> (state_ff == ST_IDLE))
      else $error("sequencer still running after the final element");

endmodule
